// ===== hw/rtl/c_expression_tokenizer_macros.svh =====
// Assertion macros shared by the tokenizer RTL.
// Needs i_clk and i_rst_n in the scope where a macro is used.
`ifndef C_EXPRESSION_TOKENIZER_MACROS_SVH
`define C_EXPRESSION_TOKENIZER_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define CET_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("tokenizer check failed");

// Next-cycle implication, checked outside reset.
`define CET_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("tokenizer check failed");

`endif

// ===== hw/rtl/cet_pkg.sv =====
// Package for the C expression tokenizer: item types, token kind codes
// and character class functions. No dependencies.
`timescale 1ns / 1ps

package cet_pkg;

    localparam int unsigned CHAR_W = 8;
    localparam int unsigned KIND_W = 5;

    typedef logic [CHAR_W-1:0] t_char;
    typedef logic [KIND_W-1:0] t_kind;

    // Token kinds
    localparam t_kind KIND_IDENT   = 5'd0;
    localparam t_kind KIND_CONST   = 5'd1;
    localparam t_kind KIND_QUAL    = 5'd2;   // . or ->
    localparam t_kind KIND_MINUS   = 5'd3;
    localparam t_kind KIND_LPAREN  = 5'd4;
    localparam t_kind KIND_RPAREN  = 5'd5;
    localparam t_kind KIND_LBRACK  = 5'd6;
    localparam t_kind KIND_RBRACK  = 5'd7;
    localparam t_kind KIND_PLUS    = 5'd8;
    localparam t_kind KIND_STAR    = 5'd9;
    localparam t_kind KIND_SLASH   = 5'd10;
    localparam t_kind KIND_CARET   = 5'd11;
    localparam t_kind KIND_BANG    = 5'd12;
    localparam t_kind KIND_TILDE   = 5'd13;
    localparam t_kind KIND_LT      = 5'd14;
    localparam t_kind KIND_GT      = 5'd15;
    localparam t_kind KIND_LSH     = 5'd16;
    localparam t_kind KIND_RSH     = 5'd17;
    localparam t_kind KIND_AND     = 5'd18;
    localparam t_kind KIND_LAND    = 5'd19;
    localparam t_kind KIND_OR      = 5'd20;
    localparam t_kind KIND_LOR     = 5'd21;
    localparam t_kind KIND_ASN     = 5'd22;
    localparam t_kind KIND_EQU     = 5'd23;
    localparam t_kind KIND_UNKNOWN = 5'd24;

    typedef struct packed {
        t_char char_in;
        logic  end_of_input;
    } t_in_item;

    typedef struct packed {
        t_char char_out;
        t_kind token_kind;
        logic  token_first;
        logic  token_last;
    } t_out_item;

    function automatic logic is_letter(input t_char c);
        return (c >= "A" && c <= "Z") || (c >= "a" && c <= "z") || c == "_";
    endfunction

    function automatic logic is_digit(input t_char c);
        return c >= "0" && c <= "9";
    endfunction

    function automatic logic is_hex_or_x(input t_char c);
        return is_digit(c) || (c >= "a" && c <= "f") || (c >= "A" && c <= "F")
            || c == "x" || c == "X";
    endfunction

    function automatic logic is_space(input t_char c);
        return c == " " || c == 8'h09 || c == 8'h0D || c == 8'h0A;
    endfunction

    function automatic t_kind start_kind(input t_char c);
        t_kind k;
        if (is_letter(c)) begin
            k = KIND_IDENT;
        end else if (is_digit(c)) begin
            k = KIND_CONST;
        end else begin
            case (c)
                ".":     k = KIND_QUAL;
                "-":     k = KIND_MINUS;
                "(":     k = KIND_LPAREN;
                ")":     k = KIND_RPAREN;
                "[":     k = KIND_LBRACK;
                "]":     k = KIND_RBRACK;
                "+":     k = KIND_PLUS;
                "*":     k = KIND_STAR;
                "/":     k = KIND_SLASH;
                "^":     k = KIND_CARET;
                "!":     k = KIND_BANG;
                "~":     k = KIND_TILDE;
                "<":     k = KIND_LT;
                ">":     k = KIND_GT;
                "&":     k = KIND_AND;
                "|":     k = KIND_OR;
                "=":     k = KIND_ASN;
                default: k = KIND_UNKNOWN;
            endcase
        end
        return k;
    endfunction

endpackage

// ===== hw/rtl/c_expression_tokenizer.sv =====
// Top level of the C expression tokenizer.
// Depends on cet_pkg and c_expression_tokenizer_macros.svh.
`timescale 1ns / 1ps

// Streaming lexer for C-like expressions. One byte enters per item; each kept
// character leaves one item later, tagged with its token kind and first/last
// marks. That one-character lookahead settles two-character operators
// (-> << >> && || ==) and the ends of identifiers and constants. Space, tab,
// CR and LF produce nothing and close any open token. An item with
// end_of_input set carries no character: it flushes the pending character
// (marked last) and returns the lexer to its reset state. Each item gives
// zero or one result. Throughput is one item per clock while the input is not
// stalled; classification and pairing are one level of logic between the
// held-character registers and a two-entry output stage (result register plus
// skid), which registers each result, into the skid if the output register is
// stalled. Input is stalled only while both output entries are full.
module c_expression_tokenizer (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_stall,
    input  cet_pkg::t_in_item i_in_item,
    output logic              o_out_valid,
    input  logic              i_out_stall,
    output cet_pkg::t_out_item o_out_item
);
    import cet_pkg::*;

`include "c_expression_tokenizer_macros.svh"

    // Pending character: the one whose token end is not yet known.
    t_char r_held_char,  n_held_char;
    t_kind r_held_kind,  n_held_kind;
    logic  r_held_valid, n_held_valid;
    logic  r_held_first, n_held_first;

    // Output register and skid entry.
    t_out_item r_out, r_skid;
    logic      r_out_valid, r_skid_valid;

    logic      accept, pop;
    logic      res_valid;
    t_out_item res;
    t_char     c;
    logic      pair_hit;
    t_kind     pair_k;
    logic      cont;

    assign c      = i_in_item.char_in;
    assign accept = i_in_valid && !o_in_stall;
    assign pop    = r_out_valid && !i_out_stall;

    // Does the pending first character pair up with c?
    always_comb begin
        pair_hit = 1'b0;
        pair_k   = KIND_QUAL;
        if (r_held_first) begin
            case (r_held_kind)
                KIND_MINUS: begin pair_hit = (c == ">"); pair_k = KIND_QUAL; end
                KIND_LT:    begin pair_hit = (c == "<"); pair_k = KIND_LSH;  end
                KIND_GT:    begin pair_hit = (c == ">"); pair_k = KIND_RSH;  end
                KIND_AND:   begin pair_hit = (c == "&"); pair_k = KIND_LAND; end
                KIND_OR:    begin pair_hit = (c == "|"); pair_k = KIND_LOR;  end
                KIND_ASN:   begin pair_hit = (c == "="); pair_k = KIND_EQU;  end
                default:    begin pair_hit = 1'b0;       pair_k = KIND_QUAL; end
            endcase
        end
    end

    // Does c extend the pending token?
    always_comb begin
        if (pair_hit) begin
            cont = 1'b1;
        end else if (r_held_kind == KIND_IDENT) begin
            cont = is_letter(c) || is_digit(c);
        end else if (r_held_kind == KIND_CONST) begin
            cont = is_hex_or_x(c);
        end else begin
            cont = 1'b0;
        end
    end

    // One step of the lexer: result for this item and next pending state.
    always_comb begin
        res.char_out    = r_held_char;
        res.token_kind  = r_held_kind;
        res.token_first = r_held_first;
        res.token_last  = 1'b1;
        res_valid       = 1'b0;
        n_held_char     = r_held_char;
        n_held_kind     = r_held_kind;
        n_held_valid    = r_held_valid;
        n_held_first    = r_held_first;

        if (i_in_item.end_of_input) begin
            // flush and restart
            res_valid    = r_held_valid;
            n_held_char  = '0;
            n_held_kind  = KIND_IDENT;
            n_held_valid = 1'b0;
            n_held_first = 1'b0;
        end else if (r_held_valid && cont) begin
            res_valid       = 1'b1;
            res.token_last  = 1'b0;
            res.token_kind  = pair_hit ? pair_k : r_held_kind;
            n_held_char     = c;
            n_held_kind     = pair_hit ? pair_k : r_held_kind;
            n_held_first    = 1'b0;
        end else begin
            // pending token (if any) ends here; c may open a new one
            res_valid    = r_held_valid;
            n_held_valid = 1'b0;
            if (!is_space(c)) begin
                n_held_char  = c;
                n_held_kind  = start_kind(c);
                n_held_first = 1'b1;
                n_held_valid = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_held_char  <= '0;
            r_held_kind  <= KIND_IDENT;
            r_held_valid <= 1'b0;
            r_held_first <= 1'b0;
        end else if (accept) begin
            r_held_char  <= n_held_char;
            r_held_kind  <= n_held_kind;
            r_held_valid <= n_held_valid;
            r_held_first <= n_held_first;
        end
    end

    // Two-entry output: the skid takes a result while the output register is
    // stalled, and input stalls only while the skid is occupied.
    logic push;
    assign push = accept && res_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else begin
            if (r_skid_valid) begin
                if (pop) begin
                    r_out_valid  <= 1'b1;
                    r_skid_valid <= 1'b0;
                end
            end else if (push) begin
                if (!r_out_valid || pop) begin
                    r_out_valid <= 1'b1;
                end else begin
                    r_skid_valid <= 1'b1;
                end
            end else if (pop) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_skid_valid) begin
            if (pop) begin
                r_out <= r_skid;
            end
        end else if (push) begin
            if (!r_out_valid || pop) begin
                r_out <= res;
            end else begin
                r_skid <= res;
            end
        end
    end

    assign o_in_stall  = r_skid_valid;
    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out;

    // Skid is only ever filled behind a full output register.
    `CET_ASSERT_NOW(a_skid_behind_out, r_skid_valid, r_out_valid)
    // End of input always leaves nothing pending.
    `CET_ASSERT_NEXT(a_end_clears, accept && i_in_item.end_of_input, !r_held_valid)
    // A non-blank character is always held after it is taken.
    `CET_ASSERT_NEXT(a_char_held,
        accept && !i_in_item.end_of_input && !is_space(i_in_item.char_in), r_held_valid)
    // Kinds stay within the defined codes.
    `CET_ASSERT_NOW(a_kind_range, o_out_valid, o_out_item.token_kind <= KIND_UNKNOWN)

endmodule

// ===== sim/c_expression_tokenizer_checker.sv =====
// Scoreboard for the C expression tokenizer: predicts each token character from
// the accepted input bytes and compares it with the block's output items.
// Depends on cet_pkg.
`timescale 1ns / 1ps

module c_expression_tokenizer_checker (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    input  logic               i_in_stall,
    input  cet_pkg::t_in_item  i_in_item,
    input  logic               i_out_valid,
    input  logic               i_out_stall,
    input  cet_pkg::t_out_item i_out_item,
    output int unsigned        o_fail_count,
    output int unsigned        o_pending,
    output int unsigned        o_result_count
);
    import cet_pkg::*;

    // Lookahead register of the predicted lexer
    t_char look_char  = '0;
    logic  look_valid = 1'b0;
    t_kind look_kind  = KIND_IDENT;
    logic  look_first = 1'b0;

    t_out_item   expected_tokens[$];
    int unsigned fail_total = 0;
    int unsigned token_total = 0;

    function automatic logic starts_name(input t_char c);
        return (c >= "A" && c <= "Z") || (c >= "a" && c <= "z") || c == "_";
    endfunction

    function automatic logic is_dec(input t_char c);
        return c >= "0" && c <= "9";
    endfunction

    function automatic logic in_const(input t_char c);
        return is_dec(c) || (c >= "a" && c <= "f") || (c >= "A" && c <= "F")
            || c == "x" || c == "X";
    endfunction

    function automatic logic is_blank(input t_char c);
        return c == 8'h20 || c == 8'h09 || c == 8'h0D || c == 8'h0A;
    endfunction

    function automatic t_kind kind_of_lead(input t_char c);
        if (starts_name(c)) return KIND_IDENT;
        if (is_dec(c)) return KIND_CONST;
        case (c)
            ".":     return KIND_QUAL;
            "-":     return KIND_MINUS;
            "(":     return KIND_LPAREN;
            ")":     return KIND_RPAREN;
            "[":     return KIND_LBRACK;
            "]":     return KIND_RBRACK;
            "+":     return KIND_PLUS;
            "*":     return KIND_STAR;
            "/":     return KIND_SLASH;
            "^":     return KIND_CARET;
            "!":     return KIND_BANG;
            "~":     return KIND_TILDE;
            "<":     return KIND_LT;
            ">":     return KIND_GT;
            "&":     return KIND_AND;
            "|":     return KIND_OR;
            "=":     return KIND_ASN;
            default: return KIND_UNKNOWN;
        endcase
    endfunction

    // Does c complete a two-character operator with the held lead character?
    function automatic logic pair_with(input t_char c, output t_kind k);
        t_char second;
        k = KIND_UNKNOWN;
        if (!look_first) return 1'b0;
        case (look_kind)
            KIND_MINUS: begin second = ">"; k = KIND_QUAL; end
            KIND_LT:    begin second = "<"; k = KIND_LSH;  end
            KIND_GT:    begin second = ">"; k = KIND_RSH;  end
            KIND_AND:   begin second = "&"; k = KIND_LAND; end
            KIND_OR:    begin second = "|"; k = KIND_LOR;  end
            KIND_ASN:   begin second = "="; k = KIND_EQU;  end
            default:    return 1'b0;
        endcase
        return c == second;
    endfunction

    task automatic release_held(input t_kind k, input logic last);
        t_out_item t;
        t.char_out    = look_char;
        t.token_kind  = k;
        t.token_first = look_first;
        t.token_last  = last;
        expected_tokens.insert(expected_tokens.size(), t);
    endtask

    task automatic clear_look();
        look_char  = '0;
        look_valid = 1'b0;
        look_kind  = KIND_IDENT;
        look_first = 1'b0;
    endtask

    task automatic lex_byte(input t_in_item it);
        t_char c;
        t_kind pk;
        t_kind nk;
        logic  cont;
        c = it.char_in;
        if (it.end_of_input) begin
            if (look_valid) release_held(look_kind, 1'b1);
            clear_look();
            return;
        end
        if (look_valid) begin
            nk = look_kind;
            cont = 1'b0;
            if (pair_with(c, pk)) begin
                cont = 1'b1;
                nk = pk;
            end else if (look_kind == KIND_IDENT) begin
                cont = starts_name(c) || is_dec(c);
            end else if (look_kind == KIND_CONST) begin
                cont = in_const(c);
            end
            if (cont) begin
                release_held(nk, 1'b0);
                look_char  = c;
                look_kind  = nk;
                look_first = 1'b0;
                return;
            end
            release_held(look_kind, 1'b1);
            look_valid = 1'b0;
        end
        if (!is_blank(c)) begin
            look_char  = c;
            look_kind  = kind_of_lead(c);
            look_first = 1'b1;
            look_valid = 1'b1;
        end
    endtask

    task automatic report(input string what, input logic [31:0] want, input logic [31:0] got);
        fail_total++;
        $display("%0t: %s mismatch, expected %0h, actual %0h", $time, what, want, got);
    endtask

    task automatic check_token(input t_out_item got);
        t_out_item want;
        token_total++;
        if (expected_tokens.size() == 0) begin
            report("token with nothing expected", '0, 32'(got));
            return;
        end
        want = expected_tokens.pop_front();
        if (got.char_out !== want.char_out)
            report("char_out", 32'(want.char_out), 32'(got.char_out));
        if (got.token_kind !== want.token_kind)
            report("token_kind", 32'(want.token_kind), 32'(got.token_kind));
        if (got.token_first !== want.token_first)
            report("token_first", 32'(want.token_first), 32'(got.token_first));
        if (got.token_last !== want.token_last)
            report("token_last", 32'(want.token_last), 32'(got.token_last));
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            clear_look();
            expected_tokens.delete();
        end else begin
            if (i_in_valid && !i_in_stall) lex_byte(i_in_item);
            if (i_out_valid && !i_out_stall) check_token(i_out_item);
        end
        o_fail_count   <= fail_total;
        o_pending      <= expected_tokens.size();
        o_result_count <= token_total;
    end

endmodule

// ===== sim/tb_top.sv =====
// Top of the tokenizer testbench: clock, reset, byte stimulus and output stall.
// Depends on cet_pkg, c_expression_tokenizer and c_expression_tokenizer_checker.
`timescale 1ns / 1ps

module tb_top;
    import cet_pkg::*;

    // Generous bound: a run of about 450 items stays far below this.
    localparam int unsigned CYCLE_LIMIT = 200000;

    logic      clk;
    logic      rst_n     = 1'b0;
    logic      in_valid  = 1'b0;
    logic      in_stall;
    t_in_item  in_item   = '0;
    logic      out_valid;
    logic      out_stall = 1'b0;
    t_out_item out_item;

    // High while the receiver must not stall (calm stretch and final drain).
    logic quiet = 1'b0;

    int unsigned fail_count;
    int unsigned pending_tokens;
    int unsigned checked_tokens;
    int unsigned cycle_count = 0;

    // Byte stream, built up front and then driven item by item
    t_in_item    byte_stream[$];
    int unsigned n_ends = 0;

    // Character pools for the random expression generator
    string name_lead  = "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz_";
    string name_tail  = "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz_0123456789";
    string dec_digits = "0123456789";
    string const_tail = "0123456789abcdefABCDEFxX";
    string op_list [23] = '{"->", "<<", ">>", "&&", "||", "==", ".", "-", "(", ")",
                            "[", "]", "+", "*", "/", "^", "!", "~", "<", ">",
                            "&", "|", "="};

    c_expression_tokenizer u_dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in_item   (in_item),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out_item  (out_item)
    );

    c_expression_tokenizer_checker u_checker (
        .i_clk          (clk),
        .i_rst_n        (rst_n),
        .i_in_valid     (in_valid),
        .i_in_stall     (in_stall),
        .i_in_item      (in_item),
        .i_out_valid    (out_valid),
        .i_out_stall    (out_stall),
        .i_out_item     (out_item),
        .o_fail_count   (fail_count),
        .o_pending      (pending_tokens),
        .o_result_count (checked_tokens)
    );

    initial begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // Receiver stalls at random, 31 percent of the time, except in the calm stretch
    always @(posedge clk) begin
        out_stall <= !quiet && ($urandom_range(99) < 31);
    end

    // Watchdog: a hung handshake or a lost token ends the run here
    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles, %0d tokens still expected",
                     cycle_count, pending_tokens);
            $display("CHECK FAILED");
            $finish;
        end
    end

    function automatic t_char pick_from(input string s);
        return s[$urandom_range(s.len() - 1)];
    endfunction

    // Space, tab, CR or LF
    function automatic t_char blank_char();
        case ($urandom_range(3))
            0:       return 8'h20;
            1:       return 8'h09;
            2:       return 8'h0D;
            default: return 8'h0A;
        endcase
    endfunction

    task automatic add_byte(input t_char c);
        t_in_item it;
        it.char_in      = c;
        it.end_of_input = 1'b0;
        byte_stream.insert(byte_stream.size(), it);
    endtask

    // End marker; the char field is don't-care, so give it random bits
    task automatic add_end(input t_char c);
        t_in_item it;
        it.char_in      = c;
        it.end_of_input = 1'b1;
        byte_stream.insert(byte_stream.size(), it);
        n_ends++;
    endtask

    task automatic add_text(input string s);
        for (int i = 0; i < s.len(); i++) add_byte(s[i]);
    endtask

    // One lexeme of a plausible expression, or now and then noise or an end.
    // Lexemes mostly land back to back, so operators chain
    // (<<< and friends) and constants run into identifiers.
    task automatic add_random_token();
        int unsigned pick;
        pick = $urandom_range(99);
        if (pick < 30) begin
            add_byte(pick_from(name_lead));
            repeat ($urandom_range(5)) add_byte(pick_from(name_tail));
        end else if (pick < 50) begin
            if ($urandom_range(2) == 0) add_text("0x");
            else add_byte(pick_from(dec_digits));
            repeat ($urandom_range(4)) add_byte(pick_from(const_tail));
        end else if (pick < 78) begin
            add_text(op_list[$urandom_range(22)]);
        end else if (pick < 90) begin
            add_byte(blank_char());
        end else if (pick < 96) begin
            add_byte(t_char'($urandom_range(255)));
        end else begin
            add_end(t_char'($urandom_range(255)));
        end
        if ($urandom_range(3) == 0) add_byte(blank_char());
    endtask

    // Present one item and hold it until accepted. Unless calm, the sender
    // skips cycles at random first; valid never looks at stall.
    task automatic push_item(input t_in_item it, input logic calm);
        while (!calm && $urandom_range(99) < 31) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_item  <= it;
        do @(posedge clk); while (in_stall);
    endtask

    initial begin
        int unsigned n_directed;
        int unsigned k;
        logic        calm;

        // Directed opening:
        //   end marker and a blank with nothing held (both silent),
        //   identifier with underscore and digit, tab as separator,
        //   hex constant running into a letter, arrow, dot,
        //   <<< (pair then single), >>, &&, lone |, ==, ! and ~,
        //   unknown bytes at both ends of the range, then a flushing end.
        add_end(8'h00);
        add_byte(8'h20);
        add_text("_z9");
        add_byte(8'h09);
        add_text("0xAg->.<<<>>&&|==!~");
        add_byte(8'h00);
        add_byte(8'hFF);
        add_end(8'hA5);
        n_directed = byte_stream.size();

        while (byte_stream.size() < 450) add_random_token();

        // Synchronous reset, once
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (k = 0; k < byte_stream.size(); k++) begin
            // After the directed part, hold off until every token is out
            if (k == n_directed) begin
                in_valid <= 1'b0;
                do @(posedge clk); while (pending_tokens != 0);
            end
            // Calm stretch: neither side idles for about a hundred items
            calm = (k >= n_directed + 150) && (k < n_directed + 250);
            quiet <= calm;
            push_item(byte_stream[k], calm);
        end

        // Drain with the receiver always ready, then keep the clock running
        // to catch any token the block emits that nothing predicted
        in_valid <= 1'b0;
        quiet    <= 1'b1;
        do @(posedge clk); while (pending_tokens != 0);
        repeat (8) @(posedge clk);

        $display("Fed %0d items (%0d end markers) of directed and random expressions,",
                 byte_stream.size(), n_ends);
        $display("compared %0d token characters with %0d mismatches",
                 checked_tokens, fail_count);
        if (fail_count == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule

// ===== c_expression_tokenizer.f =====
+incdir+hw/rtl
hw/rtl/cet_pkg.sv
hw/rtl/c_expression_tokenizer.sv
sim/c_expression_tokenizer_checker.sv
sim/tb_top.sv
